/* rtl/core/bitmap_run_finder_assert.svh */
// Assertion macros for the bitmap run finder.
// Used by the top level only; needs no package.
`ifndef BITMAP_RUN_FINDER_ASSERT_SVH
`define BITMAP_RUN_FINDER_ASSERT_SVH

// same-cycle implication
`define BRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_run_finder: assertion failed");

// next-cycle implication
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_run_finder: assertion failed");

`endif

/* rtl/core/brf_pkg.sv */
// Shared types and codes for the bitmap run finder.
// No dependencies.
package brf_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_TEST  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_SCAN  = 2'd3;

   // register indexes
   localparam logic REG_BYTES_IN_USE = 1'b0;

   localparam logic [7:0] BYTES_IN_USE_RESET = 8'd128;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_TEST,
      S_WRITE,
      S_SCAN,
      S_PUSH
   } state_type;

endpackage

/* rtl/core/bitmap_run_finder.sv */
// Bitmap run finder top level: byte map in RAM, test/write/clear/scan sequencer.
// Depends on brf_pkg, brf_ram and bitmap_run_finder_assert.svh.
//
//   channel  | dir | handshake         | contents
//   ---------+-----+-------------------+-----------------------------------------
//   req_     | in  | tvalid/tready     | tuser kind; tdata index, value, length
//   rsp_     | out | tvalid/tready     | tuser found; tdata start, bit value
//   csr_     | in  | psel/penable      | bytes_in_use at address 0, pready tied
//
// Test and write read the RAM, then test the bit or modify/write it, then push.
// Scan reads one map byte a cycle over up to min(bytes_in_use, MAP_BYTES, 128)
// bytes, stopping early when a run is found. Clear sweeps the whole RAM.
// After reset a clearing pass over all MAP_BYTES bytes runs before the first
// word is taken; csr writes are accepted throughout.
// A result parks in the output register; the next word is taken while it waits.
`include "bitmap_run_finder_assert.svh"

module bitmap_run_finder #(
   parameter int MAP_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] bit_index, [10] set_value, [21:11] run_length
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] start_index, [10] bit_value
   output logic        rsp_tuser,   // [0] found
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   // scans never pass bit 1023, i.e. byte 127
   localparam int SCAN_BYTES = (MAP_BYTES < 128) ? MAP_BYTES : 128;
   localparam int SW         = $clog2(SCAN_BYTES + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

   // ---------------- configuration ----------------
   logic [7:0] biu_ff, biu_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == brf_pkg::REG_BYTES_IN_USE) ? {24'd0, biu_ff} : 32'd0;

   always_comb begin
      biu_in = biu_ff;
      if (csr_wr && csr_paddr[2] == brf_pkg::REG_BYTES_IN_USE) begin
         biu_in = csr_pwdata[7:0];
      end
   end

   // ---------------- map RAM ----------------
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   brf_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // ---------------- sequencer state ----------------
   brf_pkg::state_type state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [9:0]    bidx_ff, bidx_in;
   logic          sval_ff, sval_in;
   logic [10:0]   len_ff, len_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [SW-1:0] nbytes_ff, nbytes_in;   // bytes a scan covers
   logic [SW-1:0] rd_ptr_ff, rd_ptr_in;   // next byte to read
   logic [SW-1:0] didx_ff, didx_in;       // byte on mem_rdata
   logic          dvld_ff, dvld_in;
   logic [10:0]   cnt_ff, cnt_in;         // current free run length
   logic          res_found_ff, res_found_in;
   logic [9:0]    res_start_ff, res_start_in;
   logic          res_bit_ff, res_bit_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]   rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tuser_ff, rsp_tuser_in;

   logic          req_acc;
   logic          req_byte_ok;
   logic [SW-1:0] req_nbytes;
   logic [10:0]   req_len;

   // scan of one byte
   logic [10:0]   sc_cnt;
   logic          sc_hit;
   logic [9:0]    sc_start;
   logic [9:0]    sc_base;

   assign req_tready = (state_ff == brf_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_len    = req_tdata[21:11];
   assign req_byte_ok = 13'(req_tdata[9:3]) < 13'(MAP_BYTES);
   assign req_nbytes  = (biu_ff > 8'(SCAN_BYTES)) ? SW'(SCAN_BYTES) : SW'(biu_ff);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // walk the eight bits of the byte on the read port, lowest first
   always_comb begin
      logic [10:0] c;
      logic        f;
      logic [9:0]  st;
      c  = cnt_ff;
      f  = 1'b0;
      st = 10'd0;
      sc_base = 10'({didx_ff, 3'b000});
      for (int j = 0; j < 8; j++) begin
         if (!f) begin
            if (mem_rdata[j]) begin
               c = 11'd0;
            end else begin
               c = c + 11'd1;
            end
            if (c == len_ff) begin
               f  = 1'b1;
               st = sc_base + 10'(j) + 10'd1 - len_ff[9:0];
            end
         end
      end
      sc_cnt   = c;
      sc_hit   = f;
      sc_start = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brf_pkg::S_INIT;
         clr_ptr_ff    <= '0;
         dvld_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         biu_ff        <= brf_pkg::BYTES_IN_USE_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         dvld_ff       <= dvld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         biu_ff        <= biu_in;
      end
      kind_ff      <= kind_in;
      bidx_ff      <= bidx_in;
      sval_ff      <= sval_in;
      len_ff       <= len_in;
      nbytes_ff    <= nbytes_in;
      rd_ptr_ff    <= rd_ptr_in;
      didx_ff      <= didx_in;
      cnt_ff       <= cnt_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_bit_ff   <= res_bit_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      bidx_in       = bidx_ff;
      sval_in       = sval_ff;
      len_in        = len_ff;
      clr_ptr_in    = clr_ptr_ff;
      nbytes_in     = nbytes_ff;
      rd_ptr_in     = rd_ptr_ff;
      didx_in       = didx_ff;
      dvld_in       = 1'b0;
      cnt_in        = cnt_ff;
      res_found_in  = res_found_ff;
      res_start_in  = res_start_ff;
      res_bit_in    = res_bit_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ptr_ff;
      mem_wdata     = 8'd0;
      mem_raddr     = AW'(bidx_ff[9:3]);

      case (state_ff)
         brf_pkg::S_INIT, brf_pkg::S_CLEAR: begin
            mem_we     = 1'b1;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == LAST_ADDR) begin
               clr_ptr_in = '0;
               state_in   = (state_ff == brf_pkg::S_INIT) ? brf_pkg::S_IDLE : brf_pkg::S_PUSH;
            end
         end
         brf_pkg::S_IDLE: begin
            mem_raddr = AW'(req_tdata[9:3]);
            if (req_acc) begin
               kind_in      = req_tuser;
               bidx_in      = req_tdata[9:0];
               sval_in      = req_tdata[10];
               len_in       = req_len;
               nbytes_in    = req_nbytes;
               rd_ptr_in    = '0;
               cnt_in       = 11'd0;
               res_found_in = 1'b0;
               res_start_in = 10'd0;
               res_bit_in   = 1'b0;
               case (req_tuser)
                  brf_pkg::KIND_CLEAR: state_in = brf_pkg::S_CLEAR;
                  brf_pkg::KIND_TEST:
                     state_in = req_byte_ok ? brf_pkg::S_TEST : brf_pkg::S_PUSH;
                  brf_pkg::KIND_WRITE:
                     state_in = req_byte_ok ? brf_pkg::S_WRITE : brf_pkg::S_PUSH;
                  brf_pkg::KIND_SCAN: begin
                     // zero length, or longer than the pool: nothing to search
                     if (req_len == 11'd0 || req_len > 11'({req_nbytes, 3'b000})) begin
                        state_in = brf_pkg::S_PUSH;
                     end else begin
                        state_in = brf_pkg::S_SCAN;
                     end
                  end
                  default: state_in = brf_pkg::S_PUSH;
               endcase
            end
         end
         brf_pkg::S_TEST: begin
            res_bit_in = mem_rdata[bidx_ff[2:0]];
            state_in   = brf_pkg::S_PUSH;
         end
         brf_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(bidx_ff[9:3]);
            mem_wdata = mem_rdata;
            mem_wdata[bidx_ff[2:0]] = sval_ff;
            state_in  = brf_pkg::S_PUSH;
         end
         brf_pkg::S_SCAN: begin
            mem_raddr = AW'(rd_ptr_ff);
            if (rd_ptr_ff < nbytes_ff) begin
               dvld_in   = 1'b1;
               didx_in   = rd_ptr_ff;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (dvld_ff) begin
               cnt_in = sc_cnt;
               if (sc_hit) begin
                  res_found_in = 1'b1;
                  res_start_in = sc_start;
                  dvld_in      = 1'b0;
                  state_in     = brf_pkg::S_PUSH;
               end else if (didx_ff == SW'(nbytes_ff - 1'b1)) begin
                  dvld_in  = 1'b0;
                  state_in = brf_pkg::S_PUSH;
               end
            end
         end
         brf_pkg::S_PUSH: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'd0, res_bit_ff, res_start_ff};
               rsp_tuser_in  = res_found_ff;
               state_in      = brf_pkg::S_IDLE;
            end
         end
         default: state_in = brf_pkg::S_IDLE;
      endcase
   end

   // ---------------- checks ----------------
   // a byte under scan always lies inside the pool
   `BRF_ASSERT_IMPL(a_scan_in_pool, clock, reset,
      (state_ff == brf_pkg::S_SCAN && dvld_ff), (didx_ff < nbytes_ff))
   // a found flag only ever comes from a scan
   `BRF_ASSERT_IMPL(a_found_is_scan, clock, reset,
      (state_ff == brf_pkg::S_PUSH && res_found_ff), (kind_ff == brf_pkg::KIND_SCAN))
   // test and scan never disturb the map
   `BRF_ASSERT_IMPL(a_no_stray_write, clock, reset,
      (state_ff == brf_pkg::S_SCAN || state_ff == brf_pkg::S_TEST), (!mem_we))
   // a pushed result lands in the output register
   `BRF_ASSERT_NEXT(a_push_lands, clock, reset,
      (state_ff == brf_pkg::S_PUSH && (!rsp_tvalid_ff || rsp_tready)), (rsp_tvalid_ff))

endmodule

/* rtl/core/brf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
